// ----- design/sync_frame_receiver_crc32_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sync frame receiver
// Shared property forms used by the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SYNC_FRAME_RECEIVER_CRC32_CORE_ASSERT_SVH
`define SYNC_FRAME_RECEIVER_CRC32_CORE_ASSERT_SVH

// same-cycle implication
`define SFR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Constants, types and the CRC-32 byte step shared by the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    localparam int SYNC_BYTES      = 4;
    localparam int MAX_FRAME_BYTES = 255;
    localparam int CRC_BYTES       = 4;
    localparam int MIN_FRAME_BYTES = SYNC_BYTES + CRC_BYTES + 1;
    localparam int SYNC_SEL_W      = 2;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_PATTERN = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_LENGTH = 1'b1;

    localparam logic [31:0] SYNC_PATTERN_RESET = 32'h0000_0000;
    localparam logic [7:0]  FRAME_LEN_RESET    = 8'd64;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_CRC     = 2'd1,
        OP_STORE   = 2'd2,
        OP_RESTART = 2'd3
    } sfr_op_t;

    typedef struct packed {
        sfr_op_t     op;
        logic [1:0]  crc_idx;
        logic [7:0]  rx_byte;
        logic [7:0]  position;
        logic        payload_valid;
        logic [7:0]  payload_offset;
        logic        frame_done;
    } sfr_entry_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } sfr_q_status_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'h0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- design/sfr_if.sv -----
// ----------------------------------------------------------------------------
// Frame receiver channels
// Valid/ready byte input channel and per-byte result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfr_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] position;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_offset;
    logic       frame_done;
    logic       frame_good;

    modport source (output valid, output position, output payload_valid,
                    output payload_byte, output payload_offset,
                    output frame_done, output frame_good, input ready);
    modport sink   (input valid, input position, input payload_valid,
                    input payload_byte, input payload_offset,
                    input frame_done, input frame_good, output ready);
endinterface

`default_nettype wire

// ----- design/sync_frame_receiver_crc32_core.sv -----
// ----------------------------------------------------------------------------
// sync_frame_receiver_crc32_core
// Sync-word framer: hunts a sync pattern, passes frame bytes with offsets and
// checks a trailing little-endian CRC-32 (reflected, poly 0xEDB88320).
//
// Usage:
//   rx carries one received byte per transaction; result returns exactly
//   one transaction per input byte, in order, with position, payload fields
//   and, on the last byte of a frame, frame_done with frame_good (ack/nack).
//   Configuration: cfg_we with cfg_index 0 writes sync_pattern, 1 writes
//   frame_length; write only while no byte is in flight.
//   Path: the front end tags an accepted byte into a two-entry queue; the
//   back end applies its CRC step and registers the result.
//   Throughput: one byte per cycle while result.ready is high, bounded by
//   the byte-wide CRC update in the back end.
//   Reset: position returns to sync hunt, CRC to all ones, sync_pattern to
//   zero and frame_length to 64; no result is pending.
//   Stall: while result.ready is low the result register holds, the queue
//   fills, and rx.ready drops once two bytes wait behind it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sync_frame_receiver_crc32_core_assert.svh"

module sync_frame_receiver_crc32_core (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    sfr_rx_if.sink                              rx,
    sfr_result_if.source                        result
);
    import sfr_pkg::*;

    logic          push;
    logic          pop;
    sfr_entry_t    push_data;
    sfr_entry_t    pop_data;
    sfr_q_status_t q_status;

    sfr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    sfr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    sfr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .entry    (pop_data),
        .pop      (pop),
        .result   (result)
    );

    `SFR_ASSERT_IMP(a_good_needs_done, clk, rst_n, result.valid && result.frame_good, result.frame_done, "frame_good without frame_done")
    `SFR_ASSERT_IMP(a_sync_fields_zero, clk, rst_n, result.valid && !result.payload_valid, (result.payload_byte == 8'h00) && (result.payload_offset == 8'h00), "nonzero payload during sync")
    `SFR_ASSERT_IMP(a_done_restarts, clk, rst_n, result.valid && result.frame_done, (result.position == 8'h00) && result.payload_valid, "frame end without restart")
    `SFR_ASSERT_NEXT(a_queue_no_phantom, clk, rst_n, q_status.empty && !push, q_status.empty, "queue filled without a push")

endmodule

`default_nettype wire

// ----- design/sfr_front.sv -----
// ----------------------------------------------------------------------------
// sfr_front
// Configuration registers, sync hunt and frame position tracking; tags each
// byte with the CRC operation the back end applies.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    sfr_rx_if.sink                              rx,
    input  sfr_pkg::sfr_q_status_t              q_status,
    output logic                                push,
    output sfr_pkg::sfr_entry_t                 push_data
);
    import sfr_pkg::*;

    logic [31:0] sync_pattern_reg;
    logic [7:0]  frame_length_reg;
    logic [7:0]  pos_reg;
    logic [7:0]  pos_next;
    logic [7:0]  len_eff;
    logic [7:0]  body_end;
    logic [7:0]  crc_pos;
    logic [8:0]  pos_inc;
    logic [7:0]  want;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_pattern_reg <= SYNC_PATTERN_RESET;
            frame_length_reg <= FRAME_LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_PATTERN: sync_pattern_reg <= cfg_data[31:0];
                CFG_FRAME_LENGTH: frame_length_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign rx.ready = !q_status.full;
    assign push     = rx.valid && rx.ready;

    always_comb
    begin
        if ({1'b0, frame_length_reg} < 9'(MIN_FRAME_BYTES))
            len_eff = 8'(MIN_FRAME_BYTES);
        else if ({1'b0, frame_length_reg} > 9'(MAX_FRAME_BYTES))
            len_eff = 8'(MAX_FRAME_BYTES);
        else
            len_eff = frame_length_reg;
    end

    assign body_end = len_eff - 8'(CRC_BYTES);
    assign crc_pos  = pos_reg - body_end;
    assign pos_inc  = {1'b0, pos_reg} + 9'd1;
    assign want     = sync_pattern_reg[{pos_reg[SYNC_SEL_W-1:0], 3'b000} +: 8];

    always_comb
    begin
        push_data                = '0;
        push_data.op             = OP_NONE;
        push_data.rx_byte        = rx.rx_byte;
        pos_next                 = pos_reg;
        if (pos_reg < 8'(SYNC_BYTES))
        begin
            if (rx.rx_byte == want)
            begin
                push_data.op = OP_CRC;
                pos_next     = pos_inc[7:0];
            end
            else
            begin
                push_data.op = OP_RESTART;
                pos_next     = '0;
            end
        end
        else
        begin
            push_data.payload_valid  = 1'b1;
            push_data.payload_offset = pos_reg;
            if (pos_reg < body_end)
            begin
                push_data.op = OP_CRC;
            end
            else if (crc_pos < 8'(CRC_BYTES))
            begin
                push_data.op      = OP_STORE;
                push_data.crc_idx = crc_pos[1:0];
            end
            if (pos_inc >= {1'b0, len_eff})
            begin
                push_data.frame_done = 1'b1;
                pos_next             = '0;
            end
            else
            begin
                pos_next = pos_inc[7:0];
            end
        end
        push_data.position = pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (push)
            pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

// ----- design/sfr_queue.sv -----
// ----------------------------------------------------------------------------
// sfr_queue
// Short FIFO of tagged bytes between the front end and the CRC back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  sfr_pkg::sfr_entry_t         push_data,
    input  wire logic                   pop,
    output sfr_pkg::sfr_entry_t         pop_data,
    output sfr_pkg::sfr_q_status_t      status
);
    import sfr_pkg::*;

    sfr_entry_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign pop_data     = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ----- design/sfr_back.sv -----
// ----------------------------------------------------------------------------
// sfr_back
// Running CRC-32, received CRC capture, frame check and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  sfr_pkg::sfr_q_status_t      q_status,
    input  sfr_pkg::sfr_entry_t         entry,
    output logic                        pop,
    sfr_result_if.source                result
);
    import sfr_pkg::*;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] rcv_reg;
    logic [31:0] rcv_next;
    logic [31:0] crc_upd;
    logic [31:0] rcv_store;
    logic        good;

    logic        valid_reg;
    logic [7:0]  position_reg;
    logic        payload_valid_reg;
    logic [7:0]  payload_byte_reg;
    logic [7:0]  payload_offset_reg;
    logic        frame_done_reg;
    logic        frame_good_reg;

    assign pop = !q_status.empty && (!valid_reg || result.ready);

    assign crc_upd   = crc_byte(crc_reg, entry.rx_byte);
    assign rcv_store = rcv_reg | ({24'h0, entry.rx_byte} << {entry.crc_idx, 3'b000});

    always_comb
    begin
        crc_next = crc_reg;
        rcv_next = rcv_reg;
        case (entry.op)
            OP_CRC:     crc_next = crc_upd;
            OP_STORE:   rcv_next = rcv_store;
            OP_RESTART: ;
            OP_NONE:    ;
            default:    ;
        endcase
        good = entry.frame_done && ((~crc_next) == rcv_next);
        if (entry.frame_done || (entry.op == OP_RESTART))
        begin
            crc_next = CRC_INIT;
            rcv_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= CRC_INIT;
            rcv_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                crc_reg   <= crc_next;
                rcv_reg   <= rcv_next;
                valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            position_reg       <= entry.position;
            payload_valid_reg  <= entry.payload_valid;
            payload_byte_reg   <= entry.payload_valid ? entry.rx_byte : 8'h00;
            payload_offset_reg <= entry.payload_offset;
            frame_done_reg     <= entry.frame_done;
            frame_good_reg     <= good;
        end
    end

    assign result.valid          = valid_reg;
    assign result.position       = position_reg;
    assign result.payload_valid  = payload_valid_reg;
    assign result.payload_byte   = payload_byte_reg;
    assign result.payload_offset = payload_offset_reg;
    assign result.frame_done     = frame_done_reg;
    assign result.frame_good     = frame_good_reg;

endmodule

`default_nettype wire

// ----- sim/tb_sync_frame_receiver_crc32_core.sv -----
// ----------------------------------------------------------------------------
// tb_sync_frame_receiver_crc32_core
// Self-checking bench for the sync framer with CRC-32 check. A directed
// table runs first: sync hunt, mismatch restart, clamped length, and a known
// ack frame. Random phases follow. Each phase picks a new sync pattern and
// frame length and sends good, corrupted, cut and broken-sync frames plus
// noise. Both sides of the byte stream stall at random, and the result side
// holds off once for a long stretch. A byte-level framer model predicts each
// result transaction the table does not pin; each field is compared in order.
// ----------------------------------------------------------------------------
module tb_sync_frame_receiver_crc32_core;
    import sfr_pkg::*;

    localparam int ITEMS       = 400;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 140;
    localparam int HOLD_CYCLES = 64;
    localparam int DIR_ROWS    = 28;
    localparam int QUIET_TAIL  = 80;

    typedef struct packed {
        logic [7:0] position;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_offset;
        logic       frame_done;
        logic       frame_good;
    } frame_result_t;

    typedef struct packed {
        logic          pinned;
        frame_result_t want;
    } pinned_result_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_SYNC,
        ROW_LEN
    } row_kind_t;

    typedef struct {
        row_kind_t     kind;
        logic [31:0]   value;
        logic          pinned;
        frame_result_t want;
    } stim_row_t;

    localparam frame_result_t NO_RES = '0;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    sfr_rx_if     rx ();
    sfr_result_if res ();

    sync_frame_receiver_crc32_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx        (rx),
        .result    (res)
    );

    always #5 clk = ~clk;

    logic [31:0]    sync_word;
    logic [7:0]     frame_len;
    int             hunt_pos;
    logic [31:0]    crc_acc;
    logic [31:0]    crc_seen;

    frame_result_t  expected_results [$];
    pinned_result_t pinned_results [$];
    stim_row_t      dir_tab [DIR_ROWS];

    int errors;
    int bytes_sent;
    int bytes_in;
    int results_out;
    int frames_seen;
    int acks;
    int phases;
    int cycles;
    int hold_left;
    int stall_left;
    int quiet_from = 2147483647;
    bit hold_done;
    bit idle_en;

    function automatic logic [31:0] crc32_step(logic [31:0] c, logic [7:0] d);
        logic [31:0] r;
        int          k;
        r = c ^ {24'h0, d};
        for (k = 0; k < 8; k++)
        begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    function automatic int frame_bytes(logic [7:0] len);
        int l;
        l = len;
        if (l < MIN_FRAME_BYTES)
            l = MIN_FRAME_BYTES;
        if (l > MAX_FRAME_BYTES)
            l = MAX_FRAME_BYTES;
        return l;
    endfunction

    function automatic void restart_hunt();
        hunt_pos = 0;
        crc_acc  = CRC_INIT;
        crc_seen = '0;
    endfunction

    function automatic frame_result_t framer_step(logic [7:0] b);
        frame_result_t r;
        int            len;
        int            body_end;
        int            slot;
        r   = '0;
        len = frame_bytes(frame_len);
        if (hunt_pos < SYNC_BYTES)
        begin
            if (b == sync_word[8*hunt_pos +: 8])
            begin
                crc_acc = crc32_step(crc_acc, b);
                hunt_pos++;
            end
            else
                restart_hunt();
        end
        else
        begin
            body_end         = len - CRC_BYTES;
            r.payload_valid  = 1'b1;
            r.payload_byte   = b;
            r.payload_offset = hunt_pos[7:0];
            if (hunt_pos < body_end)
                crc_acc = crc32_step(crc_acc, b);
            else
            begin
                slot = hunt_pos - body_end;
                if (slot < CRC_BYTES)
                    crc_seen = crc_seen | ({24'h0, b} << (8 * slot));
            end
            hunt_pos++;
            if (hunt_pos >= len)
            begin
                r.frame_done = 1'b1;
                r.frame_good = ((crc_acc ^ CRC_INIT) == crc_seen);
                restart_hunt();
            end
        end
        r.position = hunt_pos[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        $display("result %0d: %s expected 0x%0h, got 0x%0h", results_out, what, want, got);
        errors++;
    endtask

    task automatic check_result(frame_result_t got);
        frame_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("transaction with nothing pending, position", 0, got.position);
            return;
        end
        want = expected_results.pop_front();
        results_out++;
        if (want.frame_done)
        begin
            frames_seen++;
            if (want.frame_good)
                acks++;
        end
        if (got.position !== want.position)
            report_mismatch("position", want.position, got.position);
        if (got.payload_valid !== want.payload_valid)
            report_mismatch("payload_valid", want.payload_valid, got.payload_valid);
        if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", want.payload_byte, got.payload_byte);
        if (got.payload_offset !== want.payload_offset)
            report_mismatch("payload_offset", want.payload_offset, got.payload_offset);
        if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", want.frame_done, got.frame_done);
        if (got.frame_good !== want.frame_good)
            report_mismatch("frame_good", want.frame_good, got.frame_good);
    endtask

    always @(posedge clk)
    begin : monitor
        pinned_result_t p;
        frame_result_t  pred;
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else if (rst_n === 1'b1)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC_PATTERN: sync_word = cfg_data;
                    CFG_FRAME_LENGTH: frame_len = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
                check_result('{res.position, res.payload_valid, res.payload_byte,
                               res.payload_offset, res.frame_done, res.frame_good});
            if (rx.valid && rx.ready)
            begin
                p    = pinned_results.pop_front();
                pred = framer_step(rx.rx_byte);
                expected_results.push_back(p.pinned ? p.want : pred);
                bytes_in++;
            end
        end
    end

    initial
    begin : result_sink
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n !== 1'b1)
                res.ready <= 1'b0;
            else if (!hold_done && bytes_in >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
                res.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                res.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                res.ready <= 1'b0;
            end
            else
                res.ready <= 1'b1;
        end
    end

    task automatic send_byte(logic [7:0] b, logic pinned = 1'b0, frame_result_t want = '0);
        pinned_result_t p;
        int             gap;
        p.pinned = pinned;
        p.want   = want;
        pinned_results.push_back(p);
        if (bytes_sent >= quiet_from)
            idle_en = 1'b0;
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            rx.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        rx.valid   <= 1'b1;
        rx.rx_byte <= b;
        @(posedge clk);
        while (rx.ready !== 1'b1)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        rx.valid <= 1'b0;
        while (expected_results.size() != 0 || pinned_results.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [31:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // cut: stop short of the last byte so the frame stays open
    task automatic send_frame(logic [31:0] sw, logic [7:0] len, bit corrupt, bit cut);
        logic [7:0]  fb [$];
        logic [31:0] c;
        int          n;
        int          stop;
        int          i;
        int          flip;
        n = frame_bytes(len);
        c = CRC_INIT;
        for (i = 0; i < SYNC_BYTES; i++)
        begin
            fb.push_back(sw[8*i +: 8]);
            c = crc32_step(c, sw[8*i +: 8]);
        end
        for (i = 0; i < n - SYNC_BYTES - CRC_BYTES; i++)
        begin
            fb.push_back(8'($urandom_range(0, 255)));
            c = crc32_step(c, fb[fb.size()-1]);
        end
        c = ~c;
        for (i = 0; i < CRC_BYTES; i++)
            fb.push_back(c[8*i +: 8]);
        if (corrupt)
        begin
            flip     = $urandom_range(SYNC_BYTES, n - 1);
            fb[flip] = fb[flip] ^ (8'h01 << $urandom_range(0, 7));
        end
        stop = cut ? $urandom_range(SYNC_BYTES + 1, n - 1) : n;
        for (i = 0; i < stop; i++)
            send_byte(fb[i]);
    endtask

    task automatic send_broken_sync(logic [31:0] sw);
        int k;
        int i;
        k = $urandom_range(0, SYNC_BYTES - 1);
        for (i = 0; i < k; i++)
            send_byte(sw[8*i +: 8]);
        send_byte(sw[8*k +: 8] ^ 8'($urandom_range(1, 255)));
    endtask

    initial
    begin
        logic [31:0] sw;
        logic [7:0]  fl;
        logic [7:0]  b8;
        int          r;
        int          nseq;
        int          big_phases;
        int          stop_at;
        int          i;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_SYNC_PATTERN;
        cfg_data   = '0;
        rx.valid   = 1'b0;
        rx.rx_byte = 8'h00;
        sync_word  = SYNC_PATTERN_RESET;
        frame_len  = FRAME_LEN_RESET;
        restart_hunt();
        big_phases = 0;

        dir_tab = '{
            '{ROW_BYTE, 32'hFF, 1'b1, '{8'd0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0}},
            '{ROW_SYNC, 32'h3433_3231, 1'b0, NO_RES},
            '{ROW_LEN,  32'd0, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h31, 1'b1, '{8'd1, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0}},
            '{ROW_BYTE, 32'h31, 1'b1, '{8'd0, 1'b0, 8'h00, 8'd0, 1'b0, 1'b0}},
            '{ROW_BYTE, 32'h31, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h32, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h33, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h34, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h00, 1'b0, NO_RES},
            '{ROW_BYTE, 32'hFF, 1'b0, NO_RES},
            '{ROW_BYTE, 32'hFF, 1'b0, NO_RES},
            '{ROW_BYTE, 32'hFF, 1'b0, NO_RES},
            '{ROW_BYTE, 32'hFF, 1'b1, '{8'd0, 1'b1, 8'hFF, 8'd8, 1'b1, 1'b0}},
            '{ROW_LEN,  32'd13, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h31, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h32, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h33, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h34, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h35, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h36, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h37, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h38, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h39, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h26, 1'b0, NO_RES},
            '{ROW_BYTE, 32'h39, 1'b0, NO_RES},
            '{ROW_BYTE, 32'hF4, 1'b0, NO_RES},
            '{ROW_BYTE, 32'hCB, 1'b1, '{8'd0, 1'b1, 8'hCB, 8'd12, 1'b1, 1'b1}}
        };

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_en = 1'b1;
        for (i = 0; i < DIR_ROWS; i++)
        begin
            case (dir_tab[i].kind)
                ROW_SYNC:
                begin
                    drain();
                    write_reg(CFG_SYNC_PATTERN, dir_tab[i].value);
                end
                ROW_LEN:
                begin
                    drain();
                    write_reg(CFG_FRAME_LENGTH, dir_tab[i].value);
                end
                default:
                    send_byte(dir_tab[i].value[7:0], dir_tab[i].pinned, dir_tab[i].want);
            endcase
        end

        stop_at    = bytes_sent + ITEMS;
        quiet_from = stop_at - QUIET_TAIL;
        while (bytes_sent < stop_at)
        begin
            drain();
            case (phases)
                0:
                begin
                    sw = 32'h0000_0000;
                    fl = 8'd9;
                end
                1:
                begin
                    sw = 32'hFFFF_FFFF;
                    fl = 8'd255;
                    big_phases++;
                end
                default:
                begin
                    r  = $urandom_range(0, 5);
                    b8 = 8'($urandom_range(0, 255));
                    sw = (r == 0) ? {4{b8}} : $urandom();
                    r  = $urandom_range(0, 19);
                    if (r == 0)
                        fl = 8'($urandom_range(0, 8));
                    else if (r == 1 && big_phases < 2)
                    begin
                        fl = 8'd255;
                        big_phases++;
                    end
                    else if (r < 5)
                        fl = 8'($urandom_range(25, 80));
                    else
                        fl = 8'($urandom_range(9, 24));
                end
            endcase
            write_reg(CFG_SYNC_PATTERN, sw);
            write_reg(CFG_FRAME_LENGTH, {24'h0, fl});
            idle_en = (bytes_sent < quiet_from) && ($urandom_range(0, 3) != 0);
            nseq    = (frame_bytes(fl) > 100) ? 1 : $urandom_range(3, 8);
            repeat (nseq)
            begin
                if (bytes_sent >= stop_at)
                    break;
                r = $urandom_range(0, 19);
                if (r < 13)
                    send_frame(sw, fl, 1'b0, 1'b0);
                else if (r < 15)
                    send_frame(sw, fl, 1'b1, 1'b0);
                else if (r < 17)
                    send_broken_sync(sw);
                else
                    repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
            if (bytes_sent < stop_at && $urandom_range(0, 3) == 0)
                send_frame(sw, fl, 1'b0, 1'b1);
            phases++;
        end

        drain();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch("transactions never returned, count", expected_results.size(), 0);
        $display("Covered %0d bytes in %0d random phases plus the directed table.",
                 bytes_sent, phases);
        $display("Closed %0d frames: %0d ack, %0d nack; long receiver hold-off %0s.",
                 frames_seen, acks, frames_seen - acks, hold_done ? "applied" : "skipped");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
